>>> src/nnue_pkg.sv
// Package with shared constants, types and arithmetic helpers for the NNUE evaluation unit.
package nnue_pkg;

   localparam int HiddenSize   = 256;
   localparam int FeatureCount = 768;
   localparam int ClipLimit    = 255;
   localparam int FinalDivisor = 16320;
   localparam int OutputScale  = 400;

   localparam int HidW  = $clog2(HiddenSize);
   localparam int OwW   = $clog2(2 * HiddenSize);
   localparam int RowW  = 10;
   localparam int ElemW = 9;
   localparam int FwW   = $clog2(FeatureCount * HiddenSize);
   localparam int IdxW  = HidW + 1;

   // Division by a constant d: quotient = (m * Recip) >> (32 + Shift), with
   // Recip = ceil(2^(32+Shift) / d) and Shift = ceil(log2 d). This is exact
   // for every magnitude m below 2^32, which covers both divisions here.
   localparam int ClipShift  = $clog2(ClipLimit);
   localparam int FinalShift = $clog2(FinalDivisor);
   localparam logic [32:0] ClipRecip =
      33'(((64'd1 << (32 + ClipShift)) + 64'(ClipLimit) - 64'd1) / 64'(ClipLimit));
   localparam logic [32:0] FinalRecip =
      33'(((64'd1 << (32 + FinalShift)) + 64'(FinalDivisor) - 64'd1) / 64'(FinalDivisor));

   typedef enum logic [2:0] {
      KIND_WR_FEATURE = 3'd0,
      KIND_WR_OUTPUT  = 3'd1,
      KIND_WR_ACC     = 3'd2,
      KIND_ADD_ROW    = 3'd3,
      KIND_SUB_ROW    = 3'd4,
      KIND_EVALUATE   = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ROW_READ,
      ST_ROW_WRITE,
      ST_EVAL_READ,
      ST_EVAL_MAC,
      ST_EVAL_DIV,
      ST_EVAL_SCALE,
      ST_EVAL_FINAL,
      ST_RESULT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load;
      logic            clear_step;
      logic            row_read;
      logic            row_write;
      logic            eval_read;
      logic            eval_mac;
      logic            div_step;
      logic            scale;
      logic            final_step;
      logic            idx_clear;
      logic            idx_inc;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic            idx_last;
      logic            div_done;
      kind_type        kind;
      logic            row_ok;
   } stat_type;

endpackage

>>> src/nnue_ram.sv
// Generic single-port RAM with registered read.
module nnue_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // One read per cycle, plus a write to the same address when wr_en is set; the read then returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> src/nnue_ctrl.sv
// Controller state machine of the NNUE evaluation unit.
module nnue_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  nnue_pkg::stat_type stat,
   output nnue_pkg::cmd_type  cmd
);
   nnue_pkg::state_type state_ff, state_in;
   logic cmd_pending_ff, cmd_pending_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nnue_pkg::ST_CLEAR: if (stat.idx_last) state_in = nnue_pkg::ST_IDLE;
         nnue_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = nnue_pkg::ST_IDLE;
            end
         end
         nnue_pkg::ST_ROW_READ: state_in = nnue_pkg::ST_ROW_WRITE;
         nnue_pkg::ST_ROW_WRITE: begin
            if (stat.idx_last) state_in = nnue_pkg::ST_IDLE;
            else state_in = nnue_pkg::ST_ROW_READ;
         end
         nnue_pkg::ST_EVAL_READ: state_in = nnue_pkg::ST_EVAL_MAC;
         nnue_pkg::ST_EVAL_MAC: begin
            if (stat.idx_last) state_in = nnue_pkg::ST_EVAL_DIV;
            else state_in = nnue_pkg::ST_EVAL_READ;
         end
         nnue_pkg::ST_EVAL_DIV: if (stat.div_done) state_in = nnue_pkg::ST_EVAL_SCALE;
         nnue_pkg::ST_EVAL_SCALE: state_in = nnue_pkg::ST_EVAL_FINAL;
         nnue_pkg::ST_EVAL_FINAL: if (stat.div_done) state_in = nnue_pkg::ST_RESULT;
         nnue_pkg::ST_RESULT: if (rsp_tready) state_in = nnue_pkg::ST_IDLE;
         default: state_in = nnue_pkg::ST_IDLE;
      endcase
      // A freshly latched item is dispatched in the cycle after its acceptance.
      if (state_ff == nnue_pkg::ST_IDLE && cmd_pending_ff) begin
         priority if (stat.kind == nnue_pkg::KIND_EVALUATE)
            state_in = nnue_pkg::ST_EVAL_READ;
         else if ((stat.kind == nnue_pkg::KIND_ADD_ROW ||
                   stat.kind == nnue_pkg::KIND_SUB_ROW) && stat.row_ok)
            state_in = nnue_pkg::ST_ROW_READ;
         else
            state_in = nnue_pkg::ST_IDLE;
      end
   end

   // Outputs.
   always_comb begin
      cmd            = '0;
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      cmd_pending_in = 1'b0;
      unique case (state_ff)
         nnue_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            cmd.idx_inc    = 1'b1;
         end
         nnue_pkg::ST_IDLE: begin
            req_tready     = !cmd_pending_ff;
            cmd.load       = req_tvalid && !cmd_pending_ff;
            cmd_pending_in = cmd.load;
            cmd.idx_clear  = 1'b1;
         end
         nnue_pkg::ST_ROW_READ:  cmd.row_read = 1'b1;
         nnue_pkg::ST_ROW_WRITE: begin
            cmd.row_write = 1'b1;
            cmd.idx_inc   = 1'b1;
         end
         nnue_pkg::ST_EVAL_READ: cmd.eval_read = 1'b1;
         nnue_pkg::ST_EVAL_MAC: begin
            cmd.eval_mac = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         nnue_pkg::ST_EVAL_DIV:   cmd.div_step = 1'b1;
         nnue_pkg::ST_EVAL_SCALE: cmd.scale = 1'b1;
         nnue_pkg::ST_EVAL_FINAL: cmd.final_step = 1'b1;
         nnue_pkg::ST_RESULT:     rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   // State registers; reset starts the accumulator clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= nnue_pkg::ST_CLEAR;
         cmd_pending_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmd_pending_ff <= cmd_pending_in;
      end
   end
endmodule

>>> src/nnue_dp.sv
// Datapath of the NNUE evaluation unit: memories, accumulators, MAC and scaling.
module nnue_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   input  logic [2:0]          req_kind,
   input  logic                req_perspective,
   input  logic [9:0]          req_feature_row,
   input  logic [8:0]          req_element_index,
   input  logic [15:0]         req_write_value,
   input  nnue_pkg::cmd_type   cmd,
   output nnue_pkg::stat_type  stat,
   output logic [31:0]         rsp_evaluation
);
   localparam int Hs = nnue_pkg::HiddenSize;

   // Latched item.
   logic [2:0]  kind_ff;
   logic        persp_ff;
   logic [9:0]  row_ff;
   logic [8:0]  elem_ff;
   logic [15:0] val_ff;
   logic signed [15:0] bias_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         persp_ff <= req_perspective;
         row_ff   <= req_feature_row;
         elem_ff  <= req_element_index;
         val_ff   <= req_write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) bias_ff <= '0;
      else if (csr_wr_en) bias_ff <= csr_wr_data;
   end

   // Element counter; the evaluation walks both views, so it carries one more bit.
   logic [nnue_pkg::IdxW-1:0] idx_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.idx_clear) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
   end
   logic [nnue_pkg::HidW-1:0] col;
   assign col = idx_ff[nnue_pkg::HidW-1:0];
   logic eval_them;
   assign eval_them = idx_ff[nnue_pkg::HidW];

   logic is_row, is_eval;
   assign is_row  = (kind_ff == nnue_pkg::KIND_ADD_ROW) || (kind_ff == nnue_pkg::KIND_SUB_ROW);
   assign is_eval = (kind_ff == nnue_pkg::KIND_EVALUATE);

   // Single-item writes happen in the cycle after the item is latched.
   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else pend_ff <= cmd.load;
   end

   // Feature weight memory.
   logic                      fw_we;
   logic [nnue_pkg::FwW-1:0]  fw_addr;
   logic [15:0]               fw_rd;
   logic [nnue_pkg::FwW+1:0]  fw_full;
   assign fw_we = pend_ff && (kind_ff == nnue_pkg::KIND_WR_FEATURE) &&
                  ({1'b0, row_ff} < 11'(nnue_pkg::FeatureCount)) &&
                  ({1'b0, elem_ff} < 10'(Hs));
   always_comb begin
      fw_full = (nnue_pkg::FwW+2)'(row_ff) * (nnue_pkg::FwW+2)'(Hs);
      if (fw_we) fw_full = fw_full + (nnue_pkg::FwW+2)'(elem_ff);
      else       fw_full = fw_full + (nnue_pkg::FwW+2)'(col);
   end
   assign fw_addr = fw_full[nnue_pkg::FwW-1:0];

   nnue_ram #(.Width(16), .Depth(nnue_pkg::FeatureCount * Hs)) u_fw (
      .clock(clock), .wr_en(fw_we), .addr(fw_addr), .wr_data(val_ff), .rd_data(fw_rd)
   );

   // Output weight memory.
   logic                     ow_we;
   logic [nnue_pkg::OwW-1:0] ow_addr;
   logic [15:0]              ow_rd;
   assign ow_we = pend_ff && (kind_ff == nnue_pkg::KIND_WR_OUTPUT) &&
                  ({1'b0, elem_ff} < 10'(2 * Hs));
   assign ow_addr = ow_we ? elem_ff[nnue_pkg::OwW-1:0] : idx_ff[nnue_pkg::OwW-1:0];

   nnue_ram #(.Width(16), .Depth(2 * Hs)) u_ow (
      .clock(clock), .wr_en(ow_we), .addr(ow_addr), .wr_data(val_ff), .rd_data(ow_rd)
   );

   // Accumulator memories, one per view.
   logic                      acc_wr_single;
   logic                      w_we, b_we;
   logic [nnue_pkg::HidW-1:0] acc_addr;
   logic [15:0]               acc_wdata, w_rd, b_rd, row_view;
   logic                      sel_white;
   assign acc_wr_single = pend_ff && (kind_ff == nnue_pkg::KIND_WR_ACC) &&
                          ({1'b0, elem_ff} < 10'(Hs));
   assign sel_white = is_eval ? (persp_ff ^ eval_them) : persp_ff;
   assign row_view  = persp_ff ? w_rd : b_rd;
   always_comb begin
      acc_addr  = col;
      acc_wdata = '0;
      w_we      = 1'b0;
      b_we      = 1'b0;
      if (cmd.clear_step) begin
         w_we = 1'b1;
         b_we = 1'b1;
      end else if (acc_wr_single) begin
         acc_addr  = elem_ff[nnue_pkg::HidW-1:0];
         acc_wdata = val_ff;
         w_we      = persp_ff;
         b_we      = !persp_ff;
      end else if (cmd.row_write) begin
         acc_wdata = (kind_ff == nnue_pkg::KIND_ADD_ROW) ? row_view + fw_rd : row_view - fw_rd;
         w_we      = persp_ff;
         b_we      = !persp_ff;
      end
   end

   nnue_ram #(.Width(16), .Depth(Hs)) u_white (
      .clock(clock), .wr_en(w_we), .addr(acc_addr), .wr_data(acc_wdata), .rd_data(w_rd)
   );
   nnue_ram #(.Width(16), .Depth(Hs)) u_black (
      .clock(clock), .wr_en(b_we), .addr(acc_addr), .wr_data(acc_wdata), .rd_data(b_rd)
   );

   // SCReLU multiply-accumulate: clamp, square, then weight (registered between).
   logic        sel_white_ff;
   logic signed [15:0] a_view;
   logic [7:0]  clip;
   logic [15:0] sq_ff;
   logic [15:0] ow_ff;
   logic        sq_vld_ff;
   logic [31:0] sum_ff;
   always_ff @(posedge clock) sel_white_ff <= sel_white;
   assign a_view = sel_white_ff ? w_rd : b_rd;
   always_comb begin
      priority if (a_view < 0) clip = '0;
      else if (a_view > 16'(nnue_pkg::ClipLimit)) clip = 8'(nnue_pkg::ClipLimit);
      else clip = a_view[7:0];
   end
   always_ff @(posedge clock) begin
      if (reset) sq_vld_ff <= 1'b0;
      else sq_vld_ff <= cmd.eval_mac;
      if (cmd.eval_mac) begin
         sq_ff <= clip * clip;
         ow_ff <= ow_rd;
      end
   end
   logic signed [31:0] prod;
   assign prod = $signed({1'b0, sq_ff}) * $signed(ow_ff);
   always_ff @(posedge clock) begin
      if (cmd.load) sum_ff <= '0;
      else if (sq_vld_ff) sum_ff <= sum_ff + prod;
   end

   // Division by a constant through a reciprocal multiply on magnitudes,
   // truncating toward zero: load, multiply, then the quotient is ready.
   // The sum division waits until the last product has been added.
   logic signed [47:0] scaled_ff;
   logic signed [47:0] dv_src;
   logic [47:0]        dv_abs;
   logic [31:0]        dv_mag_ff;
   logic               dv_neg_ff, dv_fin_ff;
   logic [1:0]         dv_stage_ff;
   logic [32:0]        dv_recip;
   logic [64:0]        dv_prod_ff;
   logic [31:0]        dv_quo;
   logic signed [47:0] q1_signed;
   assign dv_src    = cmd.div_step ? 48'($signed(sum_ff)) : scaled_ff;
   assign dv_abs    = dv_src[47] ? 48'(-dv_src) : 48'(dv_src);
   assign dv_recip  = dv_fin_ff ? nnue_pkg::FinalRecip : nnue_pkg::ClipRecip;
   assign dv_quo    = dv_fin_ff ? 32'(dv_prod_ff >> (32 + nnue_pkg::FinalShift))
                                : 32'(dv_prod_ff >> (32 + nnue_pkg::ClipShift));
   assign q1_signed = dv_neg_ff ? -$signed({16'b0, dv_quo}) : $signed({16'b0, dv_quo});

   assign stat.div_done = (dv_stage_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_stage_ff <= 2'd0;
      end else begin
         unique case (dv_stage_ff)
            2'd0: begin
               if ((cmd.div_step && !sq_vld_ff) || cmd.final_step) begin
                  dv_mag_ff   <= dv_abs[31:0];
                  dv_neg_ff   <= dv_src[47];
                  dv_fin_ff   <= cmd.final_step;
                  dv_stage_ff <= 2'd1;
               end
            end
            2'd1: begin
               dv_prod_ff  <= dv_mag_ff * dv_recip;
               dv_stage_ff <= 2'd2;
            end
            default: dv_stage_ff <= 2'd0;
         endcase
      end
   end

   // Add the bias and scale.
   logic signed [47:0] q_ff;
   always_ff @(posedge clock) begin
      if (stat.div_done && cmd.div_step) q_ff <= 48'(q1_signed);
      if (cmd.scale) begin
         scaled_ff <= (q_ff + 48'(bias_ff)) * 48'(nnue_pkg::OutputScale);
      end
   end
   // The last quotient; it is saturated to the signed 32-bit range.
   logic signed [47:0] fin;
   assign fin = q1_signed;
   logic [31:0] eval_ff;
   always_ff @(posedge clock) begin
      if (stat.div_done && cmd.final_step) begin
         priority if (fin > 48'sd2147483647) eval_ff <= 32'h7fffffff;
         else if (fin < -48'sd2147483648) eval_ff <= 32'h80000000;
         else eval_ff <= fin[31:0];
      end
   end
   assign rsp_evaluation = eval_ff;

   // Status back to the controller.
   assign stat.idx_last = is_eval && !cmd.clear_step && !cmd.row_write
                          ? (idx_ff == {nnue_pkg::IdxW{1'b1}})
                          : (col == {nnue_pkg::HidW{1'b1}});
   assign stat.kind     = nnue_pkg::kind_type'(kind_ff);
   assign stat.row_ok   = ({1'b0, row_ff} < 11'(nnue_pkg::FeatureCount)) && (is_row || is_eval);
endmodule

>>> src/nnue_accumulator_screlu_eval_unit.sv
// Top level of the NNUE accumulator and SCReLU evaluation unit.
// After reset the unit clears both accumulators in one pass over all HiddenSize
// entries before it takes its first item. A row add or subtract reads and then
// writes the accumulator once per element; an evaluation walks both views with
// a multiply-accumulate over every element, then does two divisions by
// constants, each a reciprocal multiply, and the bias and scale step; its
// result then waits in an output register until taken.
module nnue_accumulator_screlu_eval_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // signed bias added before the final scaling
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[2:0], perspective[3], feature_row[13:4], element_index[22:14],
   // write_value[38:23], zero fill to 40 bits
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata      // evaluation
);
   nnue_pkg::cmd_type  cmd;
   nnue_pkg::stat_type stat;

   nnue_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .cmd(cmd)
   );

   nnue_dp u_dp (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_kind(req_tdata[2:0]), .req_perspective(req_tdata[3]),
      .req_feature_row(req_tdata[13:4]), .req_element_index(req_tdata[22:14]),
      .req_write_value(req_tdata[38:23]),
      .cmd(cmd), .stat(stat), .rsp_evaluation(rsp_tdata)
   );
endmodule

>>> src/nnue_checker.sv
// Port-level checker for the NNUE evaluation unit, bound to the top level.
module nnue_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   // A held result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // The unit never takes an item while a result is waiting.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("item taken with result pending");
   // No item is taken in the cycle after one was taken.
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back-to-back accept");
   // Nothing is taken or shown during reset's clearing pass start.
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> !req_tready && !rsp_tvalid)
      else $error("activity right after reset");
endmodule

bind nnue_accumulator_screlu_eval_unit nnue_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
